### hdl/wpa_pkg.sv
// Shared types, constants and window lookup functions for the window pool allocator.
`default_nettype none

package wpa_pkg;

    // Default map depth in windows
    localparam int MAX_WINDOWS_DEF = 256;

    localparam int WIN_W  = 8;
    localparam int SIZE_W = 33;
    localparam int ADDR_W = 64;
    // Offset of a window inside the region: up to 404MB + 7 * 4GB
    localparam int OFF_W  = 36;
    localparam int STR_W  = 12;

    localparam logic [ADDR_W-1:0] REG_OFFSET = 64'h0000_0000_1fc0_0000;

    // Class sizes in bytes
    localparam logic [SIZE_W-1:0] BYTES_1M  = 33'h0_0010_0000;
    localparam logic [SIZE_W-1:0] BYTES_2M  = 33'h0_0020_0000;
    localparam logic [SIZE_W-1:0] BYTES_16M = 33'h0_0100_0000;
    localparam logic [SIZE_W-1:0] BYTES_4G  = 33'h1_0000_0000;

    // Class boundaries in window numbers
    localparam logic [WIN_W-1:0] M0_C1_START = 8'd156;
    localparam logic [WIN_W-1:0] M0_C2_START = 8'd166;
    localparam logic [WIN_W-1:0] M0_END      = 8'd186;
    localparam logic [WIN_W-1:0] M1_C1_START = 8'd202;
    localparam logic [WIN_W-1:0] M1_END      = 8'd210;

    // Byte offsets where the upper classes begin
    localparam logic [OFF_W-1:0] M0_C1_OFF = 36'd163577856;   // 156 x 1MB
    localparam logic [OFF_W-1:0] M0_C2_OFF = 36'd184549376;   // plus 10 x 2MB
    localparam logic [OFF_W-1:0] M1_C1_OFF = 36'd423624704;   // 202 x 2MB

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic {
        REG_MODE = 1'b0,
        REG_BASE = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_LOC,
        S_ADDR,
        S_SETUP
    } t_state;

    // Map word operations requested by the sequencer
    typedef struct packed {
        logic rd;
        logic clr;
        logic set;
        logic rel;
    } t_map_ctl;

    typedef struct packed {
        logic              ok;
        logic [SIZE_W-1:0] bytes;
        logic [OFF_W-1:0]  off;
    } t_loc;

    typedef struct packed {
        logic             ok;
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
    } t_range;

    // Class size and region offset of a window; ok is low when out of range
    function automatic t_loc locate(input logic mode, input logic [WIN_W-1:0] win);
        t_loc             loc;
        logic [OFF_W-1:0] w;
        loc = '0;
        w   = OFF_W'(win);
        if (!mode) begin
            if (win < M0_C1_START) begin
                loc.ok    = 1'b1;
                loc.bytes = BYTES_1M;
                loc.off   = w << 20;
            end else if (win < M0_C2_START) begin
                loc.ok    = 1'b1;
                loc.bytes = BYTES_2M;
                loc.off   = M0_C1_OFF + ((w - OFF_W'(M0_C1_START)) << 21);
            end else if (win < M0_END) begin
                loc.ok    = 1'b1;
                loc.bytes = BYTES_16M;
                loc.off   = M0_C2_OFF + ((w - OFF_W'(M0_C2_START)) << 24);
            end
        end else begin
            if (win < M1_C1_START) begin
                loc.ok    = 1'b1;
                loc.bytes = BYTES_2M;
                loc.off   = w << 21;
            end else if (win < M1_END) begin
                loc.ok    = 1'b1;
                loc.bytes = BYTES_4G;
                loc.off   = M1_C1_OFF + ((w - OFF_W'(M1_C1_START)) << 32);
            end
        end
        return loc;
    endfunction

    // Window range to search for a request: first fitting class up to the top
    function automatic t_range alloc_range(input logic mode, input logic [SIZE_W-1:0] req);
        t_range rng;
        rng = '0;
        if (!mode) begin
            rng.hi = M0_END;
            if (req <= BYTES_1M) begin
                rng.ok = 1'b1;
                rng.lo = '0;
            end else if (req <= BYTES_2M) begin
                rng.ok = 1'b1;
                rng.lo = M0_C1_START;
            end else if (req <= BYTES_16M) begin
                rng.ok = 1'b1;
                rng.lo = M0_C2_START;
            end
        end else begin
            rng.hi = M1_END;
            if (req <= BYTES_2M) begin
                rng.ok = 1'b1;
                rng.lo = '0;
            end else if (req <= BYTES_4G) begin
                rng.ok = 1'b1;
                rng.lo = M1_C1_START;
            end
        end
        return rng;
    endfunction

endpackage

`default_nettype wire

### hdl/wpa_map.sv
// Taken-window map held as 32-bit words, with read-modify-write and first-free search.
`default_nettype none

module wpa_map #(
    parameter int MAX_WINDOWS = wpa_pkg::MAX_WINDOWS_DEF
) (
    input  wire logic                                      i_clk,
    input  wire wpa_pkg::t_map_ctl                         i_ctl,
    input  wire logic [$clog2((MAX_WINDOWS + 31) / 32)-1:0] i_addr,
    input  wire logic [4:0]                                i_bit,
    input  wire logic [wpa_pkg::WIN_W-1:0]                 i_lo,
    input  wire logic [wpa_pkg::WIN_W-1:0]                 i_hi,
    output logic                                           o_hit,
    output logic [4:0]                                     o_hit_bit
);

    localparam int NW = (MAX_WINDOWS + 31) / 32;
    localparam int AW = $clog2(NW);
    localparam int IW = AW + 5;

    logic [31:0]   r_mem [NW];
    logic [31:0]   r_rdata;
    logic [AW-1:0] r_rd_word;
    logic [31:0]   free_bits;
    logic [31:0]   bit_mask;

    assign bit_mask = 32'd1 << i_bit;

    // Word memory: clear a whole word, or set or release one bit of the word just read
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_mem[i_addr] <= '0;
        end else if (i_ctl.set) begin
            r_mem[i_addr] <= r_rdata | bit_mask;
        end else if (i_ctl.rel) begin
            r_mem[i_addr] <= r_rdata & ~bit_mask;
        end
        if (i_ctl.rd) begin
            r_rdata   <= r_mem[i_addr];
            r_rd_word <= i_addr;
        end
    end

    // Free windows of the read word that fall inside the search range
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            free_bits[j] = !r_rdata[j]
                && ({r_rd_word, 5'(j)} >= IW'(i_lo))
                && ({r_rd_word, 5'(j)} <  IW'(i_hi));
        end
    end

    // Lowest free bit
    always_comb begin
        o_hit_bit = '0;
        for (int j = 31; j >= 0; j--) begin
            if (free_bits[j]) begin
                o_hit_bit = 5'(j);
            end
        end
    end

    assign o_hit = |free_bits;

endmodule

`default_nettype wire

### hdl/window_pool_allocator.sv
// Top level of the window pool allocator: command sequencer, registers and address unit.
//
// Usage:
//   Commands enter on start while busy is low: allocate (requested size, 0 = any
//   window), release and query (window number). Each command gives exactly one
//   result, shown for one cycle with o_strobe; the receiver cannot hold it off.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once
//   (0 = arch mode, 1 = region base). A mode write starts a map clear.
// Sequencing (one command at a time, busy high meanwhile):
//   query or rejected command: locate, address and setup steps, then strobe;
//   release: map read and bit release first; allocate: a map read and check for
//   each map word searched until a free window or the last word. The search reads
//   one 32-bit map word at a time (registered read, then check and update).
//   One shared 64-bit adder forms the window address, then the setup address.
// Reset: control registers clear to zero, then a clear pass zeroes the map, one
//   word a cycle, (MAX_WINDOWS + 31) / 32 words (8 at the default); busy stays
//   high during it. The same pass runs after every mode write.
`default_nettype none

module window_pool_allocator #(
    parameter int MAX_WINDOWS = wpa_pkg::MAX_WINDOWS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command request
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_command,
    input  wire logic [wpa_pkg::SIZE_W-1:0]    i_requested_size,
    input  wire logic [wpa_pkg::WIN_W-1:0]     i_window_number,
    // result
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic [wpa_pkg::WIN_W-1:0]          o_granted_window,
    output logic [wpa_pkg::SIZE_W-1:0]         o_window_bytes,
    output logic [wpa_pkg::ADDR_W-1:0]         o_window_address,
    output logic [wpa_pkg::ADDR_W-1:0]         o_setup_reg_address,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [wpa_pkg::ADDR_W-1:0]    i_cfg_data
);

    localparam int NW = (MAX_WINDOWS + 31) / 32;
    localparam int AW = $clog2(NW);
    localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

    // control registers
    wpa_pkg::t_state                r_state,  n_state;
    logic [AW-1:0]                  r_word,   n_word;
    logic                           r_done,   n_done;
    logic                           r_mode,   n_mode;
    logic [wpa_pkg::ADDR_W-1:0]     r_base,   n_base;
    // working and result registers
    wpa_pkg::t_cmd                  r_cmd,    n_cmd;
    wpa_pkg::t_status               r_status, n_status;
    logic [wpa_pkg::WIN_W-1:0]      r_win,    n_win;
    logic [wpa_pkg::WIN_W-1:0]      r_lo,     n_lo;
    logic [wpa_pkg::WIN_W-1:0]      r_hi,     n_hi;
    logic [AW-1:0]                  r_last,   n_last;
    wpa_pkg::t_loc                  r_loc,    n_loc;
    logic [wpa_pkg::SIZE_W-1:0]     r_bytes,  n_bytes;
    logic [wpa_pkg::ADDR_W-1:0]     r_addr,   n_addr;
    logic [wpa_pkg::ADDR_W-1:0]     r_setup,  n_setup;

    wpa_pkg::t_map_ctl              map_ctl;
    logic [AW-1:0]                  map_addr;
    logic [4:0]                     map_bit;
    logic                           map_hit;
    logic [4:0]                     map_hit_bit;

    wpa_pkg::t_range                rng;
    logic [wpa_pkg::WIN_W-1:0]      rng_hi_m1;
    wpa_pkg::t_loc                  in_loc;
    logic                           in_win_ok;
    logic [wpa_pkg::STR_W-1:0]      stride_off;
    logic [wpa_pkg::ADDR_W-1:0]     add_b;
    logic [wpa_pkg::ADDR_W-1:0]     add_sum;

    wpa_map #(
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_map (
        .i_clk     (i_clk),
        .i_ctl     (map_ctl),
        .i_addr    (map_addr),
        .i_bit     (map_bit),
        .i_lo      (r_lo),
        .i_hi      (r_hi),
        .o_hit     (map_hit),
        .o_hit_bit (map_hit_bit)
    );

    assign rng       = wpa_pkg::alloc_range(r_mode, i_requested_size);
    assign rng_hi_m1 = rng.hi - 8'd1;
    assign in_loc    = wpa_pkg::locate(r_mode, i_window_number);
    assign in_win_ok = in_loc.ok;

    // setup register stride: 8 bytes in mode 0, 12 bytes in mode 1
    assign stride_off = r_mode
        ? (wpa_pkg::STR_W'({r_win, 3'b000}) + wpa_pkg::STR_W'({r_win, 2'b00}))
        : wpa_pkg::STR_W'({r_win, 3'b000});

    // Shared address adder: window offset first, setup register offset next
    assign add_b   = (r_state == wpa_pkg::S_SETUP)
        ? (wpa_pkg::REG_OFFSET + wpa_pkg::ADDR_W'(stride_off))
        : wpa_pkg::ADDR_W'(r_loc.off);
    assign add_sum = r_base + add_b;

    // Sequencer: next state and map operations
    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_done   = 1'b0;
        n_mode   = r_mode;
        n_base   = r_base;
        n_cmd    = r_cmd;
        n_status = r_status;
        n_win    = r_win;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_last   = r_last;
        n_loc    = r_loc;
        n_bytes  = r_bytes;
        n_addr   = r_addr;
        n_setup  = r_setup;
        map_ctl  = '0;
        map_addr = r_word;
        map_bit  = r_win[4:0];

        case (r_state)
            wpa_pkg::S_CLEAR: begin
                map_ctl.clr = 1'b1;
                if (r_word == LAST_WORD) begin
                    n_state = wpa_pkg::S_IDLE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            wpa_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd    = wpa_pkg::t_cmd'(i_command);
                    n_win    = i_window_number;
                    n_status = wpa_pkg::ST_OK;
                    n_state  = wpa_pkg::S_LOC;
                    case (wpa_pkg::t_cmd'(i_command))
                        wpa_pkg::CMD_ALLOC: begin
                            if (rng.ok) begin
                                n_lo    = rng.lo;
                                n_hi    = rng.hi;
                                n_word  = AW'(rng.lo[7:5]);
                                n_last  = AW'(rng_hi_m1[7:5]);
                                n_state = wpa_pkg::S_RD;
                            end else begin
                                n_status = wpa_pkg::ST_NOFIT;
                                n_win    = '0;
                            end
                        end
                        wpa_pkg::CMD_RELEASE: begin
                            if (in_win_ok) begin
                                n_word  = AW'(i_window_number[7:5]);
                                n_state = wpa_pkg::S_RD;
                            end else begin
                                n_status = wpa_pkg::ST_INVALID;
                            end
                        end
                        wpa_pkg::CMD_QUERY: begin
                            // range check happens in the locate step
                        end
                        default: begin
                            n_status = wpa_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            wpa_pkg::S_RD: begin
                map_ctl.rd = 1'b1;
                n_state    = wpa_pkg::S_CHK;
            end
            wpa_pkg::S_CHK: begin
                if (r_cmd == wpa_pkg::CMD_RELEASE) begin
                    map_ctl.rel = 1'b1;
                    n_state     = wpa_pkg::S_LOC;
                end else if (map_hit) begin
                    map_ctl.set = 1'b1;
                    map_bit     = map_hit_bit;
                    n_win       = wpa_pkg::WIN_W'({r_word, map_hit_bit});
                    n_state     = wpa_pkg::S_LOC;
                end else if (r_word == r_last) begin
                    n_status = wpa_pkg::ST_NOFIT;
                    n_win    = '0;
                    n_state  = wpa_pkg::S_LOC;
                end else begin
                    n_word  = r_word + AW'(1);
                    n_state = wpa_pkg::S_RD;
                end
            end
            wpa_pkg::S_LOC: begin
                n_loc = wpa_pkg::locate(r_mode, r_win);
                if (r_status == wpa_pkg::ST_OK && !n_loc.ok) begin
                    n_status = wpa_pkg::ST_INVALID;
                end
                n_state = wpa_pkg::S_ADDR;
            end
            wpa_pkg::S_ADDR: begin
                if (r_status == wpa_pkg::ST_OK) begin
                    n_bytes = r_loc.bytes;
                    n_addr  = add_sum;
                end else begin
                    n_bytes = '0;
                    n_addr  = '0;
                end
                n_state = wpa_pkg::S_SETUP;
            end
            wpa_pkg::S_SETUP: begin
                if (r_status == wpa_pkg::ST_OK) begin
                    n_setup = add_sum;
                end else begin
                    n_setup = '0;
                end
                n_done  = 1'b1;
                n_state = wpa_pkg::S_IDLE;
            end
            default: begin
                n_state = wpa_pkg::S_CLEAR;
                n_word  = '0;
            end
        endcase

        // configuration writes; a mode write restarts the map clear
        if (i_cfg_we) begin
            if (i_cfg_idx == wpa_pkg::REG_MODE) begin
                n_mode  = i_cfg_data[0];
                n_state = wpa_pkg::S_CLEAR;
                n_word  = '0;
            end else begin
                n_base = i_cfg_data;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpa_pkg::S_CLEAR;
            r_word  <= '0;
            r_done  <= 1'b0;
            r_mode  <= 1'b0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_done  <= n_done;
            r_mode  <= n_mode;
            r_base  <= n_base;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_win    <= n_win;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_last   <= n_last;
        r_loc    <= n_loc;
        r_bytes  <= n_bytes;
        r_addr   <= n_addr;
        r_setup  <= n_setup;
    end

    assign busy                = (r_state != wpa_pkg::S_IDLE);
    assign o_strobe            = r_done;
    assign o_status            = r_status;
    assign o_granted_window    = r_win;
    assign o_window_bytes      = r_bytes;
    assign o_window_address    = r_addr;
    assign o_setup_reg_address = r_setup;

endmodule

`default_nettype wire

### hdl/wpa_checker.sv
// Port-level checker for the window pool allocator, bound to the top level.
`default_nettype none

module wpa_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_strobe,
    input wire logic [1:0]                    o_status,
    input wire logic [wpa_pkg::WIN_W-1:0]     o_granted_window,
    input wire logic [wpa_pkg::SIZE_W-1:0]    o_window_bytes,
    input wire logic [wpa_pkg::ADDR_W-1:0]    o_window_address,
    input wire logic [wpa_pkg::ADDR_W-1:0]    o_setup_reg_address
);

    // A result is shown only once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // An accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A failed allocate reports no window and no addresses
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == wpa_pkg::ST_NOFIT) |->
        (o_granted_window == '0 && o_window_bytes == '0
         && o_window_address == '0 && o_setup_reg_address == '0))
        else $error("failed allocate carries nonzero fields");

    // A rejected window number gives zero size and addresses
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == wpa_pkg::ST_INVALID) |->
        (o_window_bytes == '0 && o_window_address == '0
         && o_setup_reg_address == '0))
        else $error("invalid request carries nonzero fields");

    // A good result always names a window of nonzero size
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == wpa_pkg::ST_OK) |-> (o_window_bytes != '0))
        else $error("good result with zero window size");

endmodule

bind window_pool_allocator wpa_checker u_wpa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_strobe            (o_strobe),
    .o_status            (o_status),
    .o_granted_window    (o_granted_window),
    .o_window_bytes      (o_window_bytes),
    .o_window_address    (o_window_address),
    .o_setup_reg_address (o_setup_reg_address)
);

`default_nettype wire
